// ----- sv/swept_aabb_collision_unit_assert.svh -----
// Assertion macros shared by the checker
`ifndef SWEPT_AABB_COLLISION_UNIT_ASSERT_SVH
`define SWEPT_AABB_COLLISION_UNIT_ASSERT_SVH

// same-cycle implication
`define SACU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sacu check failed");

// next-cycle implication
`define SACU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sacu check failed");

`endif

// ----- sv/sacu_pkg.sv -----
`timescale 1ns / 1ps
package sacu_pkg;

   localparam int LANES = 4;

   localparam logic signed [1:0] NORM_ZERO = 2'sb00;
   localparam logic signed [1:0] NORM_POS  = 2'sb01;
   localparam logic signed [1:0] NORM_NEG  = 2'sb11;

   typedef struct packed {
      logic neg_res;
      logic pos_sat;
   } lane_flags_type;

   typedef struct packed {
      lane_flags_type [LANES-1:0] lane;
      logic                       ovl_x;
      logic                       ovl_y;
      logic                       gap_x_neg;
      logic                       gap_y_neg;
   } side_type;

endpackage

// ----- sv/swept_aabb_collision_unit.sv -----
`timescale 1ns / 1ps
// Swept box test, fully pipelined: one word accepted every cycle, busy is never raised.
// A request passes the input, setup, divider, clamp and decision registers on its way to rsp_valid.
// The four entry/exit divisions run as restoring dividers, one quotient bit per stage.
// Synchronous active-high reset clears every valid bit; payload registers are not reset.
// The receiver cannot stall: each result shows for exactly one cycle.
module swept_aabb_collision_unit #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_a_x,
   input  logic signed [COORD_BITS-1:0] req_a_y,
   input  logic        [COORD_BITS-2:0] req_a_w,
   input  logic        [COORD_BITS-2:0] req_a_h,
   input  logic signed [COORD_BITS-1:0] req_vel_x,
   input  logic signed [COORD_BITS-1:0] req_vel_y,
   input  logic signed [COORD_BITS-1:0] req_b_x,
   input  logic signed [COORD_BITS-1:0] req_b_y,
   input  logic        [COORD_BITS-2:0] req_b_w,
   input  logic        [COORD_BITS-2:0] req_b_h,
   output logic                         rsp_valid,
   output logic        [FRAC_BITS:0]    rsp_hit_time,
   output logic signed [1:0]            rsp_normal_x,
   output logic signed [1:0]            rsp_normal_y
);

   localparam int C     = COORD_BITS;
   localparam int F     = FRAC_BITS;
   localparam int OW    = C + 4;
   localparam int NW    = C + 1;
   localparam int DW    = C;
   localparam int QW    = F + 1;
   localparam int TW    = F + 3;
   localparam int STEPS = F + 1;

   localparam logic signed [TW-1:0] T_ONE = {{(TW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
   localparam logic signed [TW-1:0] T_SAT = {{(TW-F-1){1'b0}}, 1'b1, {(F-1){1'b0}}, 1'b1};
   localparam logic signed [TW-1:0] T_NEG = {TW{1'b1}};
   localparam logic        [QW-1:0] Q_SAT = {1'b1, {(F-1){1'b0}}, 1'b1};

   assign busy = 1'b0;

   // input registers, index 0 is x and 1 is y
   logic signed [C-1:0] pa_ff [2];
   logic        [C-2:0] sa_ff [2];
   logic signed [C-1:0] va_ff [2];
   logic signed [C-1:0] pb_ff [2];
   logic        [C-2:0] sb_ff [2];
   logic                in_valid_ff;

   always_ff @(posedge clock) begin
      pa_ff[0] <= req_a_x;   pa_ff[1] <= req_a_y;
      sa_ff[0] <= req_a_w;   sa_ff[1] <= req_a_h;
      va_ff[0] <= req_vel_x; va_ff[1] <= req_vel_y;
      pb_ff[0] <= req_b_x;   pb_ff[1] <= req_b_y;
      sb_ff[0] <= req_b_w;   sb_ff[1] <= req_b_h;
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start & ~busy;
      end
   end

   // setup stage: gaps, magnitudes, broadphase
   logic [NW-1:0]    num_in [sacu_pkg::LANES];
   logic [DW-1:0]    den_in [2];
   logic             ovl_in [2];
   logic             gneg_in [2];
   sacu_pkg::lane_flags_type lflag_in [sacu_pkg::LANES];

   logic [NW-1:0]    num_ff [sacu_pkg::LANES];
   logic [DW-1:0]    den_ff [2];
   sacu_pkg::side_type side_ff;
   logic             s1_valid_ff;

   for (genvar a = 0; a < 2; a++) begin : g_axis
      logic signed [OW-1:0] ap, as, v, bp, bs, sp, ss, dd, absd, gnear, gfar, gin, gout;
      logic signed [OW-1:0] gin_abs, gout_abs, v_abs;
      logic                 vpos, vneg, vzero;

      always_comb begin
         ap = {{(OW-C){pa_ff[a][C-1]}}, pa_ff[a]};
         as = {{(OW-C+1){1'b0}}, sa_ff[a]};
         v  = {{(OW-C){va_ff[a][C-1]}}, va_ff[a]};
         bp = {{(OW-C){pb_ff[a][C-1]}}, pb_ff[a]};
         bs = {{(OW-C+1){1'b0}}, sb_ff[a]};
         vneg  = va_ff[a][C-1];
         vzero = (va_ff[a] == '0);
         vpos  = !vneg && !vzero;
         sp   = vpos ? ap : ap + v;
         ss   = vpos ? as + v : as - v;
         dd   = (sp + sp + ss) - (bp + bp + bs);
         absd = dd[OW-1] ? -dd : dd;
         gnear = bp - (ap + as);
         gfar  = (bp + bs) - ap;
         gin   = vpos ? gnear : gfar;
         gout  = vpos ? gfar : gnear;
         gin_abs  = gin[OW-1] ? -gin : gin;
         gout_abs = gout[OW-1] ? -gout : gout;
         v_abs    = vneg ? -v : v;

         ovl_in[a]  = absd < (ss + bs);
         gneg_in[a] = gin[OW-1];
         num_in[2*a]     = gin_abs[NW-1:0];
         num_in[2*a + 1] = gout_abs[NW-1:0];
         den_in[a]       = v_abs[DW-1:0];
         lflag_in[2*a].neg_res     = vzero | ((gin != '0) && (gin[OW-1] != vneg));
         lflag_in[2*a].pos_sat     = 1'b0;
         lflag_in[2*a + 1].neg_res = !vzero && (gout != '0) && (gout[OW-1] != vneg);
         lflag_in[2*a + 1].pos_sat = vzero;
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < sacu_pkg::LANES; l++) begin
         num_ff[l]       <= num_in[l];
         side_ff.lane[l] <= lflag_in[l];
      end
      den_ff[0]         <= den_in[0];
      den_ff[1]         <= den_in[1];
      side_ff.ovl_x     <= ovl_in[0];
      side_ff.ovl_y     <= ovl_in[1];
      side_ff.gap_x_neg <= gneg_in[0];
      side_ff.gap_y_neg <= gneg_in[1];
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid_ff;
      end
   end

   // divider pipeline, stage k resolves quotient bit F-k
   logic [DW-1:0]      rem_ff  [STEPS][sacu_pkg::LANES];
   logic [QW-1:0]      quo_ff  [STEPS][sacu_pkg::LANES];
   logic               dsat_ff [STEPS][sacu_pkg::LANES];
   logic [DW-1:0]      dv_ff   [STEPS][2];
   sacu_pkg::side_type dside_ff [STEPS];
   logic               dval_ff [STEPS];

   for (genvar l = 0; l < sacu_pkg::LANES; l++) begin : g_first
      logic [NW-1:0] diff;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] quo_in;
      logic          sat_in;

      always_comb begin
         ge     = num_ff[l] >= {1'b0, den_ff[l/2]};
         diff   = num_ff[l] - {1'b0, den_ff[l/2]};
         sat_in = num_ff[l] >= {den_ff[l/2], 1'b0};
         rem_in = ge ? diff[DW-1:0] : num_ff[l][DW-1:0];
         quo_in = '0;
         quo_in[F] = ge;
      end

      always_ff @(posedge clock) begin
         rem_ff[0][l]  <= rem_in;
         quo_ff[0][l]  <= quo_in;
         dsat_ff[0][l] <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      dv_ff[0][0] <= den_ff[0];
      dv_ff[0][1] <= den_ff[1];
      dside_ff[0] <= side_ff;
      if (reset) begin
         dval_ff[0] <= 1'b0;
      end else begin
         dval_ff[0] <= s1_valid_ff;
      end
   end

   for (genvar k = 1; k < STEPS; k++) begin : g_step
      for (genvar l = 0; l < sacu_pkg::LANES; l++) begin : g_lane
         logic [DW:0]   shifted;
         logic [DW:0]   diff;
         logic          ge;
         logic [DW-1:0] rem_in;
         logic [QW-1:0] quo_in;

         always_comb begin
            shifted = {rem_ff[k-1][l], 1'b0};
            ge      = shifted >= {1'b0, dv_ff[k-1][l/2]};
            diff    = shifted - {1'b0, dv_ff[k-1][l/2]};
            rem_in  = ge ? diff[DW-1:0] : shifted[DW-1:0];
            quo_in  = quo_ff[k-1][l];
            quo_in[F-k] = ge;
         end

         always_ff @(posedge clock) begin
            rem_ff[k][l]  <= rem_in;
            quo_ff[k][l]  <= quo_in;
            dsat_ff[k][l] <= dsat_ff[k-1][l];
         end
      end

      always_ff @(posedge clock) begin
         dv_ff[k][0] <= dv_ff[k-1][0];
         dv_ff[k][1] <= dv_ff[k-1][1];
         dside_ff[k] <= dside_ff[k-1];
         if (reset) begin
            dval_ff[k] <= 1'b0;
         end else begin
            dval_ff[k] <= dval_ff[k-1];
         end
      end
   end

   // clamp stage: times held in -1 lsb .. 1.0 + 1 lsb, which keeps every compare exact
   logic signed [TW-1:0] tm_in [sacu_pkg::LANES];
   logic signed [TW-1:0] tm_ff [sacu_pkg::LANES];
   sacu_pkg::side_type   cside_ff;
   logic                 cval_ff;

   always_comb begin
      for (int l = 0; l < sacu_pkg::LANES; l++) begin
         if (dside_ff[STEPS-1].lane[l].neg_res) begin
            tm_in[l] = T_NEG;
         end else if (dside_ff[STEPS-1].lane[l].pos_sat || dsat_ff[STEPS-1][l] ||
                      (quo_ff[STEPS-1][l] > Q_SAT)) begin
            tm_in[l] = T_SAT;
         end else begin
            tm_in[l] = {2'b00, quo_ff[STEPS-1][l]};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < sacu_pkg::LANES; l++) begin
         tm_ff[l] <= tm_in[l];
      end
      cside_ff <= dside_ff[STEPS-1];
      if (reset) begin
         cval_ff <= 1'b0;
      end else begin
         cval_ff <= dval_ff[STEPS-1];
      end
   end

   // decision stage
   logic signed [TW-1:0] entry, leave, time_v;
   logic                 hit, x_later;
   logic signed [1:0]    nx_in, ny_in;
   logic [F:0]           hit_time_ff;
   logic signed [1:0]    normal_x_ff, normal_y_ff;
   logic                 out_valid_ff;

   always_comb begin
      x_later = tm_ff[0] > tm_ff[2];
      entry   = x_later ? tm_ff[0] : tm_ff[2];
      leave   = (tm_ff[1] < tm_ff[3]) ? tm_ff[1] : tm_ff[3];
      hit     = cside_ff.ovl_x && cside_ff.ovl_y &&
                !((entry > leave) || (tm_ff[0][TW-1] && tm_ff[2][TW-1]) ||
                  (tm_ff[0] > T_ONE) || (tm_ff[2] > T_ONE));
      time_v  = hit ? entry : T_ONE;
      nx_in   = sacu_pkg::NORM_ZERO;
      ny_in   = sacu_pkg::NORM_ZERO;
      if (hit && x_later) begin
         nx_in = cside_ff.gap_x_neg ? sacu_pkg::NORM_POS : sacu_pkg::NORM_NEG;
      end else if (hit) begin
         ny_in = cside_ff.gap_y_neg ? sacu_pkg::NORM_POS : sacu_pkg::NORM_NEG;
      end
   end

   always_ff @(posedge clock) begin
      hit_time_ff <= time_v[F:0];
      normal_x_ff <= nx_in;
      normal_y_ff <= ny_in;
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= cval_ff;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_hit_time = hit_time_ff;
   assign rsp_normal_x = normal_x_ff;
   assign rsp_normal_y = normal_y_ff;

endmodule

// ----- sv/sacu_checker.sv -----
`timescale 1ns / 1ps
`include "swept_aabb_collision_unit_assert.svh"
module sacu_checker #(
   parameter int FRAC_BITS = 16
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic [FRAC_BITS:0]   rsp_hit_time,
   input logic signed [1:0]    rsp_normal_x,
   input logic signed [1:0]    rsp_normal_y
);

   localparam int LAT = FRAC_BITS + 5;
   localparam logic [FRAC_BITS:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic hit_shown;
   logic nx_set;
   logic ny_set;

   assign hit_shown = rsp_valid && (rsp_hit_time != T_ONE);
   assign nx_set    = rsp_normal_x != sacu_pkg::NORM_ZERO;
   assign ny_set    = rsp_normal_y != sacu_pkg::NORM_ZERO;

   `SACU_ASSERT_NOW(a_never_busy, clock, reset, 1'b1, !busy)
   `SACU_ASSERT_NOW(a_latency, clock, reset, rsp_valid, $past(start, LAT))
   `SACU_ASSERT_NOW(a_time_range, clock, reset, rsp_valid, rsp_hit_time <= T_ONE)
   `SACU_ASSERT_NOW(a_hit_normal, clock, reset, hit_shown, nx_set != ny_set)
   `SACU_ASSERT_NOW(a_one_normal, clock, reset, rsp_valid, !(nx_set && ny_set))

endmodule

bind swept_aabb_collision_unit sacu_checker #(.FRAC_BITS(FRAC_BITS)) u_sacu_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_hit_time(rsp_hit_time),
   .rsp_normal_x(rsp_normal_x),
   .rsp_normal_y(rsp_normal_y)
);
